@@ sv/mlex_pkg.sv @@
package mlex_pkg;

    // Sizing
    localparam int MAX_TOKEN_LEN = 63;
    localparam int POSITION_BITS = 16;
    localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
    localparam int FIFO_DEPTH    = 8;
    localparam int PTR_W         = $clog2(FIFO_DEPTH);
    localparam int CNT_W         = PTR_W + 1;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [30:0]              NUM_MAX = 31'h7FFF_FFFF;

    // Keyword patterns, first five identifier bytes right aligned
    localparam logic [39:0] KW_INT   = 40'h00_0069_6E74;
    localparam logic [39:0] KW_LET   = 40'h00_006C_6574;
    localparam logic [39:0] KW_PRINT = 40'h70_7269_6E74;

    // Characters of interest
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;

    typedef enum logic [4:0] {
        K_INT    = 5'd0,
        K_IDENT  = 5'd1,
        K_ASSIGN = 5'd2,
        K_NUMBER = 5'd3,
        K_PLUS   = 5'd4,
        K_MINUS  = 5'd5,
        K_STAR   = 5'd6,
        K_PRINT  = 5'd7,
        K_LPAREN = 5'd8,
        K_RPAREN = 5'd9,
        K_SEMI   = 5'd10,
        K_LET    = 5'd11,
        K_SLASH  = 5'd12,
        K_LT     = 5'd13,
        K_LE     = 5'd14,
        K_GT     = 5'd15,
        K_GE     = 5'd16,
        K_EQ     = 5'd17,
        K_NEQ    = 5'd18,
        K_EOF    = 5'd19,
        K_BAD    = 5'd20,
        K_OPENC  = 5'd21
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_NUM   = 4'd1,
        M_IDENT = 4'd2,
        M_HOLD  = 4'd3,
        M_LINEC = 4'd4,
        M_BLOCK = 4'd5,
        M_BSTAR = 4'd6
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] value;
        logic [15:0] line;
        logic [15:0] col;
        logic [5:0]  len;
        logic        last;
    } t_tok;

    // Tokens produced by one source byte
    typedef struct packed {
        logic [1:0]       cnt;
        t_tok [1:0]       toks;
    } t_push;

endpackage

@@ sv/mlex_core.sv @@
module mlex_core
    import mlex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_char,
    input  logic       i_eoi,
    output t_push      o_push
);

    t_mode                    r_mode,  n_mode;
    logic [7:0]               r_held,  n_held;
    logic [30:0]              r_acc,   n_acc;
    logic [39:0]              r_pref,  n_pref;
    logic [LEN_W-1:0]         r_len,   n_len;
    logic [POSITION_BITS-1:0] r_line,  n_line;
    logic [POSITION_BITS-1:0] r_col,   n_col;
    logic [POSITION_BITS-1:0] r_sline, n_sline;
    logic [POSITION_BITS-1:0] r_scol,  n_scol;

    logic                     c_digit, c_alpha, c_space, c_hold;
    logic [POSITION_BITS-1:0] col_up, line_up;
    logic [LEN_W-1:0]         len_up;
    logic [34:0]              num_wide;
    logic [30:0]              num_sat;
    t_kind                    ident_kind, held_kind, pair_kind, single_kind;

    function automatic t_tok mk_tok(t_kind kind, logic [30:0] value,
                                    logic [POSITION_BITS-1:0] line,
                                    logic [POSITION_BITS-1:0] col,
                                    logic [LEN_W-1:0] len);
        t_tok t;
        t.kind  = kind;
        t.value = value;
        t.line  = 16'(line);
        t.col   = 16'(col);
        t.len   = 6'(len);
        t.last  = 1'b0;
        return t;
    endfunction

    // Character classes and saturating increments
    assign c_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign c_alpha = ((i_char >= CH_LA) && (i_char <= CH_LZ)) ||
                     ((i_char >= CH_UA) && (i_char <= CH_UZ));
    assign c_space = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign c_hold  = (i_char == CH_EQ) || (i_char == CH_BANG) || (i_char == CH_LT) ||
                     (i_char == CH_GT) || (i_char == CH_SLASH);

    assign col_up  = (r_col  == POS_MAX) ? r_col  : r_col  + 1'b1;
    assign line_up = (r_line == POS_MAX) ? r_line : r_line + 1'b1;
    assign len_up  = (r_len < LEN_W'(MAX_TOKEN_LEN)) ? r_len + 1'b1 : r_len;

    // acc * 10 + digit, clamped to 31 bits
    assign num_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) +
                      35'(i_char - CH_ZERO);
    assign num_sat  = (num_wide > 35'(NUM_MAX)) ? NUM_MAX : num_wide[30:0];

    // Kind lookups
    always_comb begin
        ident_kind = K_IDENT;
        if (r_len == LEN_W'(3) && r_pref == KW_INT) begin
            ident_kind = K_INT;
        end else if (r_len == LEN_W'(3) && r_pref == KW_LET) begin
            ident_kind = K_LET;
        end else if (r_len == LEN_W'(5) && r_pref == KW_PRINT) begin
            ident_kind = K_PRINT;
        end
    end

    always_comb begin
        case (r_held)
            CH_EQ:    held_kind = K_ASSIGN;
            CH_LT:    held_kind = K_LT;
            CH_GT:    held_kind = K_GT;
            CH_SLASH: held_kind = K_SLASH;
            default:  held_kind = K_BAD;
        endcase
    end

    always_comb begin
        case (r_held)
            CH_EQ:   pair_kind = K_EQ;
            CH_BANG: pair_kind = K_NEQ;
            CH_LT:   pair_kind = K_LE;
            default: pair_kind = K_GE;
        endcase
    end

    always_comb begin
        case (i_char)
            CH_PLUS:   single_kind = K_PLUS;
            CH_MINUS:  single_kind = K_MINUS;
            CH_STAR:   single_kind = K_STAR;
            CH_LPAREN: single_kind = K_LPAREN;
            CH_RPAREN: single_kind = K_RPAREN;
            CH_SEMI:   single_kind = K_SEMI;
            default:   single_kind = K_BAD;
        endcase
    end

    // One byte of scanning: flush the pending token, then start afresh
    always_comb begin
        logic       do_fresh;
        logic [1:0] cnt;
        t_tok [1:0] toks;

        do_fresh = 1'b0;
        cnt      = 2'd0;
        toks     = '0;
        n_mode   = r_mode;
        n_held   = r_held;
        n_acc    = r_acc;
        n_pref   = r_pref;
        n_len    = r_len;
        n_line   = r_line;
        n_col    = r_col;
        n_sline  = r_sline;
        n_scol   = r_scol;

        if (i_valid && i_eoi) begin
            case (r_mode)
                M_NUM: begin
                    toks[0] = mk_tok(K_NUMBER, r_acc, r_sline, r_scol, r_len);
                    cnt     = 2'd1;
                end
                M_IDENT: begin
                    toks[0] = mk_tok(ident_kind, '0, r_sline, r_scol, r_len);
                    cnt     = 2'd1;
                end
                M_HOLD: begin
                    toks[0] = mk_tok(held_kind, '0, r_sline, r_scol, LEN_W'(1));
                    cnt     = 2'd1;
                end
                M_BLOCK, M_BSTAR: begin
                    toks[0] = mk_tok(K_OPENC, '0, r_sline, r_scol, LEN_W'(2));
                    cnt     = 2'd1;
                end
                default: ;
            endcase
            toks[cnt[0]] = mk_tok(K_EOF, '0, r_line, r_col, '0);
            cnt          = cnt + 2'd1;
            // Back to reset for the next source
            n_mode  = M_IDLE;
            n_held  = '0;
            n_acc   = '0;
            n_pref  = '0;
            n_len   = '0;
            n_line  = POSITION_BITS'(1);
            n_col   = POSITION_BITS'(1);
            n_sline = '0;
            n_scol  = '0;
        end else if (i_valid) begin
            case (r_mode)
                M_NUM: begin
                    if (c_digit) begin
                        n_acc = num_sat;
                        n_len = len_up;
                        n_col = col_up;
                    end else begin
                        toks[0]  = mk_tok(K_NUMBER, r_acc, r_sline, r_scol, r_len);
                        cnt      = 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (c_alpha || c_digit) begin
                        if (r_len < LEN_W'(5)) begin
                            n_pref = {r_pref[31:0], i_char};
                        end
                        n_len = len_up;
                        n_col = col_up;
                    end else begin
                        toks[0]  = mk_tok(ident_kind, '0, r_sline, r_scol, r_len);
                        cnt      = 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_HOLD: begin
                    if (r_held == CH_SLASH && i_char == CH_SLASH) begin
                        n_mode = M_LINEC;
                        n_col  = col_up;
                    end else if (r_held == CH_SLASH && i_char == CH_STAR) begin
                        n_mode = M_BLOCK;
                        n_col  = col_up;
                    end else if (r_held != CH_SLASH && i_char == CH_EQ) begin
                        toks[0] = mk_tok(pair_kind, '0, r_sline, r_scol, LEN_W'(2));
                        cnt     = 2'd1;
                        n_col   = col_up;
                        n_mode  = M_IDLE;
                    end else begin
                        toks[0]  = mk_tok(held_kind, '0, r_sline, r_scol, LEN_W'(1));
                        cnt      = 2'd1;
                        do_fresh = 1'b1;
                    end
                end
                M_LINEC: begin
                    if (i_char == CH_NL) begin
                        do_fresh = 1'b1;
                    end else begin
                        n_col = col_up;
                    end
                end
                M_BLOCK, M_BSTAR: begin
                    if (i_char == CH_STAR) begin
                        n_mode = M_BSTAR;
                    end else if (r_mode == M_BSTAR && i_char == CH_SLASH) begin
                        n_mode = M_IDLE;
                    end else begin
                        n_mode = M_BLOCK;
                    end
                    if (i_char == CH_NL) begin
                        n_line = line_up;
                        n_col  = POSITION_BITS'(1);
                    end else begin
                        n_col = col_up;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase

            // Start of a new token, or skip whitespace
            if (do_fresh) begin
                n_mode = M_IDLE;
                if (c_space) begin
                    if (i_char == CH_NL) begin
                        n_line = line_up;
                        n_col  = POSITION_BITS'(1);
                    end else begin
                        n_col = col_up;
                    end
                end else begin
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_col   = col_up;
                    if (c_digit) begin
                        n_mode = M_NUM;
                        n_acc  = 31'(i_char - CH_ZERO);
                        n_len  = LEN_W'(1);
                    end else if (c_alpha) begin
                        n_mode = M_IDENT;
                        n_pref = {32'b0, i_char};
                        n_len  = LEN_W'(1);
                    end else if (c_hold) begin
                        n_mode = M_HOLD;
                        n_held = i_char;
                    end else begin
                        toks[cnt[0]] = mk_tok(single_kind, '0, r_line, r_col, LEN_W'(1));
                        cnt          = cnt + 2'd1;
                    end
                end
            end
        end

        // Mark the final token of this byte
        if (cnt != 2'd0) begin
            toks[cnt[0] ^ 1'b1].last = 1'b1;
        end
        o_push.cnt  = cnt;
        o_push.toks = toks;
    end

    // Scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_held  <= '0;
            r_acc   <= '0;
            r_pref  <= '0;
            r_len   <= '0;
            r_line  <= POSITION_BITS'(1);
            r_col   <= POSITION_BITS'(1);
            r_sline <= '0;
            r_scol  <= '0;
        end else begin
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_acc   <= n_acc;
            r_pref  <= n_pref;
            r_len   <= n_len;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
        end
    end

endmodule

@@ sv/mlex_fifo.sv @@
module mlex_fifo
    import mlex_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_push            i_push,
    input  logic             i_pop,
    output t_tok             o_head,
    output logic [CNT_W-1:0] o_count
);

    t_tok             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_count, n_count;

    // Pointer and fill arithmetic
    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.cnt);
        n_rp    = r_rp + PTR_W'(i_pop);
        n_count = r_count + CNT_W'(i_push.cnt) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    // Store up to two tokens per cycle
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.toks[0];
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + 1'b1] <= i_push.toks[1];
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_count = r_count;

endmodule

@@ sv/mini_c_lexer.sv @@
// Streaming lexer for a small C-like language.
// Slave channel: one source byte per beat in i_s_tdata; i_s_tlast marks the
// end of the source (the data byte of that beat is ignored). That beat
// flushes any pending token and then produces an EOF token.
// Master channel: one token per beat; o_m_tlast is set on the last token
// caused by one input byte (a byte causes zero, one or two tokens).
// Path: the byte that completes a token passes through the input register,
// then the scan logic writes the token into the token queue, and o_m_tvalid
// rises once the queue's fill count has registered it. Throughput: one byte
// per cycle while o_s_tready is high, set by the single scan pass over the
// registered byte; bytes that yield two tokens take two output beats, so the
// eight-entry queue drains at one token per cycle while i_m_tready is high.
// o_s_tready depends only on registered fill state, never on i_m_tready.
// When the receiver stalls, tokens collect in the queue and o_s_tready drops
// once fewer than two entries would remain free for a new byte after the
// byte in flight has taken its two.
// Reset (synchronous, active low) empties the queue, drops the byte in the
// input register and returns the position to line 1, column 1.
module mini_c_lexer
    import mlex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_byte
    input  logic        i_s_tlast,   // end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [4:0] token_kind, [35:5] number_value, [51:36] start_line,
    // [67:52] start_column, [73:68] token_length, [79:74] zero
    output logic [79:0] o_m_tdata,
    output logic        o_m_tlast    // last_of_run
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             r_in_eoi;
    t_push            w_push;
    t_tok             w_head;
    logic [CNT_W-1:0] w_count;
    logic             w_pop;
    logic [CNT_W:0]   w_need;

    // Room for the byte in flight and the new one, two tokens each
    assign w_need     = {1'b0, w_count} + (CNT_W+1)'({r_in_valid, 1'b0}) +
                        (CNT_W+1)'(2);
    assign o_s_tready = (w_need <= (CNT_W+1)'(FIFO_DEPTH));

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_s_tvalid && o_s_tready;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_char <= i_s_tdata;
            r_in_eoi  <= i_s_tlast;
        end
    end

    mlex_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_char  (r_in_char),
        .i_eoi   (r_in_eoi),
        .o_push  (w_push)
    );

    assign w_pop = o_m_tvalid && i_m_tready;

    mlex_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    // Output beat from the queue head
    assign o_m_tvalid = (w_count != '0);
    assign o_m_tdata  = {6'b0, w_head.len, w_head.col, w_head.line,
                         w_head.value, w_head.kind};
    assign o_m_tlast  = w_head.last;

    // Queue never overflows
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |-> ((CNT_W+1)'(w_count) + (CNT_W+1)'(w_push.cnt)
                                  <= (CNT_W+1)'(FIFO_DEPTH)))
        else $error("token queue overflow");

    // End of input always ends with an EOF token
    a_eoi_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_eoi) |->
            ((w_push.cnt == 2'd1 && w_push.toks[0].kind == K_EOF) ||
             (w_push.cnt == 2'd2 && w_push.toks[1].kind == K_EOF)))
        else $error("end of input without EOF token");

    // Two-token groups carry the run marker on the second token only
    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt == 2'd2) |-> (w_push.toks[1].last && !w_push.toks[0].last))
        else $error("run marker misplaced");

    // A stalled beat keeps its token
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled token changed");

endmodule
